FILE: rtl/core/dial_plate_step_sequencer_macros.svh
// Assertion helpers used by the sequencer engine module.
// Each helper expects signals named clk and rst_n in the using scope.
`ifndef DIAL_PLATE_STEP_SEQUENCER_MACROS_SVH
`define DIAL_PLATE_STEP_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dps_pkg.sv
package dps_pkg;

    // Dial geometry and the time span of one dial step.
    localparam int POSITIONS        = 64;
    localparam int MINUTES_PER_STEP = 15;
    localparam int POS_W            = $clog2(POSITIONS);
    localparam int POS_W1           = POS_W + 1;

    // Fixed field widths.
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MS_W     = 32;
    localparam int NEWPOS_W = 6;
    localparam int LAST_W   = 7;
    localparam int DUR_W    = 16;
    localparam int OFFSET_W = 4;
    localparam int MIN_OF_DAY_W = 11;

    // Division of minutes by the step span through a reciprocal.
    localparam int DIV_SHIFT = 20;
    localparam logic [31:0] DIV_RECIP =
        32'((2 ** DIV_SHIFT + MINUTES_PER_STEP - 1) / MINUTES_PER_STEP);
    localparam int MATCH_SPAN = 63 / MINUTES_PER_STEP;

    // Last fired minute marker meaning none.
    localparam logic [LAST_W-1:0] LAST_NONE = 7'd127;

    // Relay drive codes: bit 0 is the even relay, bit 1 the odd relay.
    localparam logic [1:0] RELAY_OFF  = 2'b00;
    localparam logic [1:0] RELAY_EVEN = 2'b01;
    localparam logic [1:0] RELAY_ODD  = 2'b10;

    // Configuration port.
    localparam int CFG_AW    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 32;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_HOUR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TURN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_SECOND = 3'd4;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_SET     = 2'd1,
        REQ_CATCHUP = 2'd2,
        REQ_MARK    = 2'd3
    } req_t;

    // Catch-up run phases.
    typedef enum logic [4:0] {
        CU_IDLE = 5'b00001,
        CU_EVEN = 5'b00010,
        CU_GAP1 = 5'b00100,
        CU_ODD  = 5'b01000,
        CU_GAP2 = 5'b10000
    } cu_phase_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset_minutes;
        logic [HOUR_W-1:0]   start_hour;
        logic [DUR_W-1:0]    half_turn_ms;
        logic [DUR_W-1:0]    gap_first_ms;
        logic [DUR_W-1:0]    gap_second_ms;
    } cfg_t;

    typedef struct packed {
        req_t                req_type;
        logic [HOUR_W-1:0]   hour_now;
        logic [MINUTE_W-1:0] minute_now;
        logic [SECOND_W-1:0] second_now;
        logic [MS_W-1:0]     now_ms;
        logic [NEWPOS_W-1:0] new_position;
        logic                smart_mode;
    } item_t;

    typedef struct packed {
        logic             even_relay;
        logic             odd_relay;
        logic [POS_W-1:0] position;
        logic             in_sync;
        logic             busy_res;
        logic             save_position;
        logic             request_ignored;
    } result_t;

endpackage

FILE: rtl/core/dps_cfg.sv
module dps_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dps_pkg::CFG_AW-1:0]    paddr,
    input  logic [dps_pkg::CFG_DW-1:0]    pwdata,
    output logic [dps_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready,
    output dps_pkg::cfg_t                 cfg
);
    import dps_pkg::*;

    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    cfg_t                 cfg_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Register writes on the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_minutes <= 4'd14;
            cfg_reg.start_hour     <= 5'd5;
            cfg_reg.half_turn_ms   <= 16'd6000;
            cfg_reg.gap_first_ms   <= 16'd200;
            cfg_reg.gap_second_ms  <= 16'd400;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_OFFSET:     cfg_reg.offset_minutes <= pwdata[OFFSET_W-1:0];
                REG_START_HOUR: cfg_reg.start_hour     <= pwdata[HOUR_W-1:0];
                REG_HALF_TURN:  cfg_reg.half_turn_ms   <= pwdata[DUR_W-1:0];
                REG_GAP_FIRST:  cfg_reg.gap_first_ms   <= pwdata[DUR_W-1:0];
                REG_GAP_SECOND: cfg_reg.gap_second_ms  <= pwdata[DUR_W-1:0];
                default:        ;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        case (reg_idx)
            REG_OFFSET:     prdata = CFG_DW'(cfg_reg.offset_minutes);
            REG_START_HOUR: prdata = CFG_DW'(cfg_reg.start_hour);
            REG_HALF_TURN:  prdata = CFG_DW'(cfg_reg.half_turn_ms);
            REG_GAP_FIRST:  prdata = CFG_DW'(cfg_reg.gap_first_ms);
            REG_GAP_SECOND: prdata = CFG_DW'(cfg_reg.gap_second_ms);
            default:        prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/dps_engine.sv
`include "dial_plate_step_sequencer_macros.svh"

module dps_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_en,
    input  dps_pkg::item_t    item,
    input  dps_pkg::cfg_t     cfg,
    output dps_pkg::result_t  res
);
    import dps_pkg::*;

    // Sequencer state.
    logic [POS_W-1:0]  dial_position_reg, dial_position_next;
    logic [LAST_W-1:0] last_fired_reg, last_fired_next;
    logic              cycle_active_reg, cycle_active_next;
    logic              second_phase_reg, second_phase_next;
    logic [MS_W-1:0]   phase_start_reg, phase_start_next;
    logic [POS_W-1:0]  steps_left_reg, steps_left_next;
    cu_phase_t         phase_reg, phase_next;
    logic [1:0]        relay_reg, relay_next;

    // Time arithmetic.
    logic [MIN_OF_DAY_W-1:0] total_min;
    logic [MIN_OF_DAY_W-1:0] begin_min;
    logic [MIN_OF_DAY_W-1:0] diff_min;
    logic [31:0]             quot_prod;
    logic [31-DIV_SHIFT:0]   quot;
    logic [POS_W-1:0]        target;
    logic [POS_W1-1:0]       ahead_wide;
    logic [POS_W-1:0]        ahead;
    logic                    minute_match;
    logic                    fire;
    logic                    tick_active;
    logic                    tick_second;
    logic [MS_W-1:0]         tick_elapsed;
    logic [MS_W-1:0]         cu_elapsed;
    logic [DUR_W-1:0]        cu_need;
    logic [POS_W-1:0]        pos_inc;
    logic [POS_W-1:0]        steps_dec;
    logic                    saved;
    logic                    ignored;

    // Target position: minutes since the first step, divided by the step span.
    always_comb
    begin
        total_min = MIN_OF_DAY_W'(item.hour_now) * MIN_OF_DAY_W'(60)
                  + MIN_OF_DAY_W'(item.minute_now);
        begin_min = MIN_OF_DAY_W'(cfg.start_hour) * MIN_OF_DAY_W'(60)
                  + MIN_OF_DAY_W'(cfg.offset_minutes);
        diff_min  = (total_min < begin_min) ? '0 : total_min - begin_min;
        quot_prod = 32'(diff_min) * DIV_RECIP;
        quot      = quot_prod[31:DIV_SHIFT];
        if (32'(quot) > 32'(POSITIONS - 1))
            target = POS_W'(POSITIONS - 1);
        else
            target = POS_W'(quot);
    end

    // Distance the dial lags behind the target, modulo the dial size.
    always_comb
    begin
        if (target >= dial_position_reg)
            ahead_wide = POS_W1'(target) - POS_W1'(dial_position_reg);
        else
            ahead_wide = POS_W1'(target) + POS_W1'(POSITIONS)
                       - POS_W1'(dial_position_reg);
        ahead = ahead_wide[POS_W-1:0];
    end

    // Minute matches the firing offset within its step period.
    always_comb
    begin
        minute_match = 1'b0;
        for (int k = 0; k <= MATCH_SPAN; k++)
        begin
            if (7'(cfg.offset_minutes) < 7'(MINUTES_PER_STEP)
                && 7'(item.minute_now) == 7'(cfg.offset_minutes) + 7'(k * MINUTES_PER_STEP))
                minute_match = 1'b1;
        end
    end

    assign pos_inc   = (dial_position_reg == POS_W'(POSITIONS - 1)) ? '0
                                                                    : dial_position_reg + 1'b1;
    assign steps_dec = (steps_left_reg != '0) ? steps_left_reg - 1'b1 : steps_left_reg;

    // Tick path: a new step fires and its timing is checked in the same item.
    assign fire = !cycle_active_reg && (item.second_now <= 6'd1)
               && (LAST_W'(item.minute_now) != last_fired_reg)
               && minute_match && (ahead != '0);
    assign tick_active  = cycle_active_reg || fire;
    assign tick_second  = fire ? 1'b0 : second_phase_reg;
    assign tick_elapsed = fire ? '0 : item.now_ms - phase_start_reg;

    // Catch-up phase timing.
    assign cu_elapsed = item.now_ms - phase_start_reg;
    always_comb
    begin
        case (phase_reg)
            CU_EVEN, CU_ODD: cu_need = cfg.half_turn_ms;
            CU_GAP1:         cu_need = cfg.gap_first_ms;
            default:         cu_need = cfg.gap_second_ms;
        endcase
    end

    // Next state for one item.
    always_comb
    begin
        dial_position_next = dial_position_reg;
        last_fired_next    = last_fired_reg;
        cycle_active_next  = cycle_active_reg;
        second_phase_next  = second_phase_reg;
        phase_start_next   = phase_start_reg;
        steps_left_next    = steps_left_reg;
        phase_next         = phase_reg;
        relay_next         = relay_reg;
        saved              = 1'b0;
        ignored            = 1'b0;

        if (item.req_type == REQ_TICK)
        begin
            if (phase_reg != CU_IDLE)
            begin
                // Catch-up run: at most one phase change per item.
                if (cu_elapsed >= MS_W'(cu_need))
                begin
                    phase_start_next = item.now_ms;
                    case (phase_reg)
                        CU_EVEN:
                        begin
                            relay_next = RELAY_OFF;
                            phase_next = CU_GAP1;
                        end
                        CU_GAP1:
                        begin
                            relay_next = RELAY_ODD;
                            phase_next = CU_ODD;
                        end
                        CU_ODD:
                        begin
                            relay_next = RELAY_OFF;
                            phase_next = CU_GAP2;
                        end
                        default:
                        begin
                            dial_position_next = pos_inc;
                            saved              = 1'b1;
                            steps_left_next    = steps_dec;
                            if (steps_dec == '0)
                                phase_next = CU_IDLE;
                            else
                            begin
                                relay_next = RELAY_EVEN;
                                phase_next = CU_EVEN;
                            end
                        end
                    endcase
                end
            end
            else
            begin
                // Regular step cycle.
                if (fire)
                begin
                    relay_next        = RELAY_EVEN;
                    phase_start_next  = item.now_ms;
                    cycle_active_next = 1'b1;
                    second_phase_next = 1'b0;
                    last_fired_next   = LAST_W'(item.minute_now);
                end
                if (tick_active && tick_elapsed >= MS_W'(cfg.half_turn_ms))
                begin
                    if (!tick_second)
                    begin
                        relay_next        = RELAY_ODD;
                        phase_start_next  = item.now_ms;
                        second_phase_next = 1'b1;
                    end
                    else
                    begin
                        relay_next         = RELAY_OFF;
                        cycle_active_next  = 1'b0;
                        second_phase_next  = 1'b0;
                        dial_position_next = pos_inc;
                        saved              = 1'b1;
                    end
                end
            end
        end
        else if (phase_reg != CU_IDLE)
        begin
            ignored = 1'b1;
        end
        else
        begin
            case (item.req_type)
                REQ_SET:
                begin
                    if (32'(item.new_position) > 32'(POSITIONS - 1))
                        dial_position_next = POS_W'(POSITIONS - 1);
                    else
                        dial_position_next = POS_W'(item.new_position);
                    saved = 1'b1;
                end
                REQ_CATCHUP:
                begin
                    if (!(item.smart_mode && ahead <= POS_W'(1)))
                    begin
                        cycle_active_next = 1'b0;
                        second_phase_next = 1'b0;
                        relay_next        = RELAY_OFF;
                        last_fired_next   = LAST_W'(item.minute_now);
                        if (ahead != '0)
                        begin
                            steps_left_next  = ahead;
                            phase_next       = CU_EVEN;
                            relay_next       = RELAY_EVEN;
                            phase_start_next = item.now_ms;
                        end
                    end
                end
                REQ_MARK:
                begin
                    last_fired_next = LAST_W'(item.minute_now);
                end
                default: ;
            endcase
        end
    end

    // Result for this item, taken from the state after it.
    always_comb
    begin
        res.even_relay      = relay_next[0];
        res.odd_relay       = relay_next[1];
        res.position        = dial_position_next;
        res.in_sync         = (dial_position_next == target);
        res.busy_res        = cycle_active_next || (phase_next != CU_IDLE);
        res.save_position   = saved;
        res.request_ignored = ignored;
    end

    // State registers advance once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dial_position_reg <= '0;
            last_fired_reg    <= LAST_NONE;
            cycle_active_reg  <= 1'b0;
            second_phase_reg  <= 1'b0;
            phase_start_reg   <= '0;
            steps_left_reg    <= '0;
            phase_reg         <= CU_IDLE;
            relay_reg         <= RELAY_OFF;
        end
        else if (item_en)
        begin
            dial_position_reg <= dial_position_next;
            last_fired_reg    <= last_fired_next;
            cycle_active_reg  <= cycle_active_next;
            second_phase_reg  <= second_phase_next;
            phase_start_reg   <= phase_start_next;
            steps_left_reg    <= steps_left_next;
            phase_reg         <= phase_next;
            relay_reg         <= relay_next;
        end
    end

    // Both relays are never energized together.
    `DPS_ASSERT_SAME(a_relay_exclusive, 1'b1, $onehot0(relay_reg), "both relays energized")
    // A catch-up run and a step cycle never overlap.
    `DPS_ASSERT_SAME(a_no_overlap, phase_reg != CU_IDLE, !cycle_active_reg, "catch-up overlaps step cycle")
    // A running catch-up always has steps left to make.
    `DPS_ASSERT_SAME(a_steps_left, phase_reg != CU_IDLE, steps_left_reg != '0, "catch-up with no steps left")
    // The second relay phase only exists inside a step cycle.
    `DPS_ASSERT_SAME(a_second_in_cycle, second_phase_reg, cycle_active_reg, "second phase outside cycle")
    // A save strobe from a tick always moves the dial.
    `DPS_ASSERT_NEXT(a_tick_save_moves, item_en && res.save_position && item.req_type == REQ_TICK, dial_position_reg != $past(dial_position_reg), "tick save without a move")

endmodule

FILE: rtl/core/dial_plate_step_sequencer.sv
// Dial plate step sequencer. Each accepted item (time tick, set position, catch-up or
// mark-synchronized request) yields exactly one result item. Items are accepted one per
// clock with no gaps while results are being taken. An accepted item waits in the input
// register, where a single pass of step and catch-up next-state logic works on it, until
// the result register can take its result. The result is registered there and presented
// in the cycle after the item leaves the input register. While a result waits on
// out_stall, the input register still takes one more item, and then in_stall rises until
// the result is taken.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8, 12 and 16 and
// should be written only while no item is in flight.
module dial_plate_step_sequencer (
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dps_pkg::CFG_AW-1:0]         paddr,
    input  logic [dps_pkg::CFG_DW-1:0]         pwdata,
    output logic [dps_pkg::CFG_DW-1:0]         prdata,
    output logic                               pready,

    // Request channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         req_type,
    input  logic [dps_pkg::HOUR_W-1:0]         hour_now,
    input  logic [dps_pkg::MINUTE_W-1:0]       minute_now,
    input  logic [dps_pkg::SECOND_W-1:0]       second_now,
    input  logic [dps_pkg::MS_W-1:0]           now_ms,
    input  logic [dps_pkg::NEWPOS_W-1:0]       new_position,
    input  logic                               smart_mode,

    // Result channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               even_relay,
    output logic                               odd_relay,
    output logic [dps_pkg::POS_W-1:0]          position,
    output logic                               in_sync,
    output logic                               busy_res,
    output logic                               save_position,
    output logic                               request_ignored
);
    import dps_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t res;
    result_t res_reg;
    logic    advance;
    logic    in_take;

    dps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held item is processed whenever the result register can take its result.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.req_type     <= req_t'(req_type);
            item_reg.hour_now     <= hour_now;
            item_reg.minute_now   <= minute_now;
            item_reg.second_now   <= second_now;
            item_reg.now_ms       <= now_ms;
            item_reg.new_position <= new_position;
            item_reg.smart_mode   <= smart_mode;
        end
    end

    dps_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign even_relay      = res_reg.even_relay;
    assign odd_relay       = res_reg.odd_relay;
    assign position        = res_reg.position;
    assign in_sync         = res_reg.in_sync;
    assign busy_res        = res_reg.busy_res;
    assign save_position   = res_reg.save_position;
    assign request_ignored = res_reg.request_ignored;

endmodule

FILE: bench/tb_dial_plate_step_sequencer.sv
`timescale 1ns / 100ps

module tb_dial_plate_step_sequencer;

    import dps_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                clk;
    logic                rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    logic                in_valid;
    logic                in_stall;
    logic [1:0]          req_type;
    logic [HOUR_W-1:0]   hour_now;
    logic [MINUTE_W-1:0] minute_now;
    logic [SECOND_W-1:0] second_now;
    logic [MS_W-1:0]     now_ms;
    logic [NEWPOS_W-1:0] new_position;
    logic                smart_mode;

    logic                out_valid;
    logic                out_stall;
    logic                even_relay;
    logic                odd_relay;
    logic [POS_W-1:0]    position;
    logic                in_sync;
    logic                busy_res;
    logic                save_position;
    logic                request_ignored;

    // Items waiting to be sent and dial results waiting to arrive.
    item_t   pend_q[$];
    result_t dial_results_q[$];
    item_t   cur_item;
    result_t seen_res;
    result_t want_res;

    int      queued_cnt;
    int      fault_cnt;
    int      cycle_cnt;
    logic    calm;
    logic [31:0] gen_ms;

    // Predictor copy of the configuration and the dial state.
    cfg_t                m_cfg;
    logic [POS_W-1:0]    m_pos;
    logic [LAST_W-1:0]   m_last;
    logic                m_cycle;
    logic                m_second;
    logic [31:0]         m_start;
    logic [POS_W-1:0]    m_left;
    cu_phase_t           m_cu;
    logic [1:0]          m_relay;

    dial_plate_step_sequencer i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .hour_now        (hour_now),
        .minute_now      (minute_now),
        .second_now      (second_now),
        .now_ms          (now_ms),
        .new_position    (new_position),
        .smart_mode      (smart_mode),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .even_relay      (even_relay),
        .odd_relay       (odd_relay),
        .position        (position),
        .in_sync         (in_sync),
        .busy_res        (busy_res),
        .save_position   (save_position),
        .request_ignored (request_ignored)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Update the dial state for one accepted item and store the result it must give.
    task automatic predict_dial(input item_t it);
        int         tot_min;
        int         base_min;
        logic [POS_W-1:0] tgt;
        logic [POS_W-1:0] behind;
        logic [31:0] elapsed;
        logic [31:0] need;
        logic       saved;
        logic       ignored;
        result_t    r;
        tot_min = int'(it.hour_now) * 60 + int'(it.minute_now);
        base_min = int'(m_cfg.start_hour) * 60 + int'(m_cfg.offset_minutes);
        if (tot_min < base_min)
            tgt = '0;
        else if ((tot_min - base_min) / MINUTES_PER_STEP > POSITIONS - 1)
            tgt = POS_W'(POSITIONS - 1);
        else
            tgt = POS_W'((tot_min - base_min) / MINUTES_PER_STEP);
        // The distance ahead wraps naturally at the position width.
        behind = tgt - m_pos;
        saved = 1'b0;
        ignored = 1'b0;

        if (it.req_type == REQ_TICK) begin
            if (m_cu != CU_IDLE) begin
                // A catch-up run moves on by at most one phase per tick.
                elapsed = it.now_ms - m_start;
                if (m_cu == CU_EVEN || m_cu == CU_ODD)
                    need = 32'(m_cfg.half_turn_ms);
                else if (m_cu == CU_GAP1)
                    need = 32'(m_cfg.gap_first_ms);
                else
                    need = 32'(m_cfg.gap_second_ms);
                if (elapsed >= need) begin
                    m_start = it.now_ms;
                    case (m_cu)
                        CU_EVEN:
                        begin
                            m_relay = RELAY_OFF;
                            m_cu = CU_GAP1;
                        end
                        CU_GAP1:
                        begin
                            m_relay = RELAY_ODD;
                            m_cu = CU_ODD;
                        end
                        CU_ODD:
                        begin
                            m_relay = RELAY_OFF;
                            m_cu = CU_GAP2;
                        end
                        default:
                        begin
                            m_pos = m_pos + 1'b1;
                            saved = 1'b1;
                            if (m_left != 0)
                                m_left = m_left - 1'b1;
                            if (m_left == 0) begin
                                m_cu = CU_IDLE;
                            end else begin
                                m_relay = RELAY_EVEN;
                                m_cu = CU_EVEN;
                            end
                        end
                    endcase
                end
            end else begin
                // A scheduled step fires once per matching minute in its first two seconds.
                if (!m_cycle && it.second_now <= 1 && {1'b0, it.minute_now} != m_last &&
                    (it.minute_now % MINUTES_PER_STEP) == m_cfg.offset_minutes &&
                    behind != 0) begin
                    m_relay = RELAY_EVEN;
                    m_start = it.now_ms;
                    m_cycle = 1'b1;
                    m_second = 1'b0;
                    m_last = {1'b0, it.minute_now};
                end
                if (m_cycle) begin
                    elapsed = it.now_ms - m_start;
                    if (elapsed >= 32'(m_cfg.half_turn_ms)) begin
                        if (!m_second) begin
                            m_relay = RELAY_ODD;
                            m_start = it.now_ms;
                            m_second = 1'b1;
                        end else begin
                            m_relay = RELAY_OFF;
                            m_cycle = 1'b0;
                            m_second = 1'b0;
                            m_pos = m_pos + 1'b1;
                            saved = 1'b1;
                        end
                    end
                end
            end
        end else if (m_cu != CU_IDLE) begin
            ignored = 1'b1;
        end else if (it.req_type == REQ_SET) begin
            // The field cannot exceed the last position, so no clamp is needed.
            m_pos = it.new_position;
            saved = 1'b1;
        end else if (it.req_type == REQ_CATCHUP) begin
            if (!(it.smart_mode && behind <= 1)) begin
                m_cycle = 1'b0;
                m_second = 1'b0;
                m_relay = RELAY_OFF;
                m_last = {1'b0, it.minute_now};
                if (behind != 0) begin
                    m_left = behind;
                    m_cu = CU_EVEN;
                    m_relay = RELAY_EVEN;
                    m_start = it.now_ms;
                end
            end
        end else begin
            m_last = {1'b0, it.minute_now};
        end

        r.even_relay = m_relay[0];
        r.odd_relay = m_relay[1];
        r.position = m_pos;
        r.in_sync = (m_pos == tgt);
        r.busy_res = m_cycle || (m_cu != CU_IDLE);
        r.save_position = saved;
        r.request_ignored = ignored;
        dial_results_q.push_back(r);
    endtask

    function automatic void check_field(string fname, logic [31:0] want_v,
                                        logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want_v,
                     got_v);
            fault_cnt++;
        end
    endfunction

    // Request driver: holds a stalled item, otherwise sends the next one or idles.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                predict_dial(cur_item);
            if (!in_valid || !in_stall) begin
                if (pend_q.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
                    cur_item = pend_q.pop_front();
                    in_valid <= 1'b1;
                    req_type <= cur_item.req_type;
                    hour_now <= cur_item.hour_now;
                    minute_now <= cur_item.minute_now;
                    second_now <= cur_item.second_now;
                    now_ms <= cur_item.now_ms;
                    new_position <= cur_item.new_position;
                    smart_mode <= cur_item.smart_mode;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Random back-pressure on the result channel.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(99) < 23);
    end

    // Result monitor: each accepted result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            seen_res.even_relay = even_relay;
            seen_res.odd_relay = odd_relay;
            seen_res.position = position;
            seen_res.in_sync = in_sync;
            seen_res.busy_res = busy_res;
            seen_res.save_position = save_position;
            seen_res.request_ignored = request_ignored;
            if (dial_results_q.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, seen_res);
                fault_cnt++;
            end else begin
                want_res = dial_results_q.pop_front();
                check_field("even_relay", want_res.even_relay, seen_res.even_relay);
                check_field("odd_relay", want_res.odd_relay, seen_res.odd_relay);
                check_field("position", want_res.position, seen_res.position);
                check_field("in_sync", want_res.in_sync, seen_res.in_sync);
                check_field("busy_res", want_res.busy_res, seen_res.busy_res);
                check_field("save_position", want_res.save_position,
                            seen_res.save_position);
                check_field("request_ignored", want_res.request_ignored,
                            seen_res.request_ignored);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     dial_results_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OFFSET:     m_cfg.offset_minutes = val[OFFSET_W-1:0];
            REG_START_HOUR: m_cfg.start_hour = val[HOUR_W-1:0];
            REG_HALF_TURN:  m_cfg.half_turn_ms = val[DUR_W-1:0];
            REG_GAP_FIRST:  m_cfg.gap_first_ms = val[DUR_W-1:0];
            default:        m_cfg.gap_second_ms = val[DUR_W-1:0];
        endcase
    endtask

    task automatic set_config(input int off, input int sh, input int half, input int g1,
                              input int g2);
        write_config(REG_OFFSET, off);
        write_config(REG_START_HOUR, sh);
        write_config(REG_HALF_TURN, half);
        write_config(REG_GAP_FIRST, g1);
        write_config(REG_GAP_SECOND, g2);
    endtask

    task automatic queue_item(input req_t rq, input logic [4:0] h, input logic [5:0] m,
                              input logic [5:0] s, input logic [31:0] ms,
                              input logic [5:0] np, input logic sm);
        item_t it;
        it.req_type = rq;
        it.hour_now = h;
        it.minute_now = m;
        it.second_now = s;
        it.now_ms = ms;
        it.new_position = np;
        it.smart_mode = sm;
        pend_q.push_back(it);
        queued_cnt++;
    endtask

    task automatic queue_tick(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s,
                              input logic [31:0] ms);
        queue_item(REQ_TICK, h, m, s, ms, 6'd0, 1'b0);
    endtask

    // Time advance between ticks, biased to the phase boundaries.
    function automatic logic [31:0] ms_step();
        case ($urandom_range(6))
            0: return 32'd0;
            1: return 32'(m_cfg.half_turn_ms) - 1;
            2: return 32'(m_cfg.half_turn_ms);
            3: return 32'(m_cfg.half_turn_ms) + $urandom_range(50);
            4: return 32'(m_cfg.gap_first_ms);
            5: return 32'(m_cfg.gap_second_ms) + $urandom_range(3);
            default: return $urandom_range(70000);
        endcase
    endfunction

    // Mostly well-formed step and catch-up sequences, with stray requests and noise.
    task automatic queue_random_traffic(input int count);
        int         goal;
        int         pick;
        int         runs;
        logic [4:0] h;
        logic [5:0] m;
        goal = queued_cnt + count;
        while (queued_cnt < goal) begin
            pick = $urandom_range(99);
            h = 5'($urandom_range(23));
            if (pick < 40) begin
                // Scheduled step at a matching minute, then ticks through both phases.
                if (m_cfg.offset_minutes < MINUTES_PER_STEP)
                    m = 6'($urandom_range(3) * MINUTES_PER_STEP + m_cfg.offset_minutes);
                else
                    m = 6'($urandom_range(59));
                gen_ms = gen_ms + ms_step();
                queue_tick(h, m, 6'($urandom_range(1)), gen_ms);
                runs = $urandom_range(2, 6);
                repeat (runs) begin
                    gen_ms = gen_ms + ms_step();
                    queue_tick(h, m, 6'($urandom_range(59)), gen_ms);
                end
            end else if (pick < 60) begin
                // Catch-up run followed by ticks, with stray requests mixed in.
                m = 6'($urandom_range(59));
                gen_ms = gen_ms + ms_step();
                queue_item(REQ_CATCHUP, h, m, 6'($urandom_range(59)), gen_ms,
                           6'd0, 1'($urandom_range(1)));
                runs = $urandom_range(4, 40);
                repeat (runs) begin
                    gen_ms = gen_ms + ms_step();
                    if ($urandom_range(99) < 85)
                        queue_tick(h, m, 6'($urandom_range(59)), gen_ms);
                    else
                        queue_item(req_t'($urandom_range(1, 3)), h, m, 6'd0, gen_ms,
                                   6'($urandom_range(63)), 1'($urandom_range(1)));
                end
            end else if (pick < 75) begin
                queue_item(REQ_SET, h, 6'($urandom_range(59)), 6'd0, gen_ms,
                           6'($urandom_range(63)), 1'($urandom_range(1)));
            end else if (pick < 85) begin
                queue_item(REQ_MARK, h, 6'($urandom_range(59)), 6'd0, gen_ms,
                           6'($urandom_range(63)), 1'($urandom_range(1)));
            end else begin
                // Noise over the full range of every field.
                queue_item(req_t'($urandom_range(3)), 5'($urandom_range(31)),
                           6'($urandom_range(63)), 6'($urandom_range(63)), $urandom,
                           6'($urandom_range(63)), 1'($urandom_range(1)));
            end
        end
    endtask

    // Wait until every queued item has been sent and every result checked.
    task automatic drain();
        @(negedge clk);
        while (pend_q.size() > 0 || in_valid || dial_results_q.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Stimulus and end of run.
    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        req_type <= REQ_TICK;
        hour_now <= '0;
        minute_now <= '0;
        second_now <= '0;
        now_ms <= '0;
        new_position <= '0;
        smart_mode <= 1'b0;
        cur_item = '0;
        queued_cnt = 0;
        fault_cnt = 0;
        cycle_cnt = 0;
        calm = 1'b0;
        m_cfg.offset_minutes = 4'd14;
        m_cfg.start_hour = 5'd5;
        m_cfg.half_turn_ms = 16'd6000;
        m_cfg.gap_first_ms = 16'd200;
        m_cfg.gap_second_ms = 16'd400;
        m_pos = '0;
        m_last = LAST_NONE;
        m_cycle = 1'b0;
        m_second = 1'b0;
        m_start = '0;
        m_left = '0;
        m_cu = CU_IDLE;
        m_relay = RELAY_OFF;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items under the reset configuration.
        queue_tick(5'd0, 6'd0, 6'd0, 32'd0);
        queue_item(REQ_SET, 5'd0, 6'd0, 6'd0, 32'd0, 6'd63, 1'b0);
        queue_item(REQ_SET, 5'd0, 6'd0, 6'd0, 32'd0, 6'd0, 1'b1);
        queue_item(REQ_MARK, 5'd5, 6'd14, 6'd0, 32'd0, 6'd0, 1'b0);
        // Scheduled step through both phases; a set during the step leaves it running.
        queue_tick(5'd5, 6'd29, 6'd0, 32'd1000);
        queue_tick(5'd5, 6'd29, 6'd1, 32'd6999);
        queue_tick(5'd5, 6'd29, 6'd1, 32'd7000);
        queue_tick(5'd5, 6'd29, 6'd0, 32'd7000);
        queue_item(REQ_SET, 5'd5, 6'd29, 6'd0, 32'd7000, 6'd5, 1'b0);
        queue_tick(5'd5, 6'd30, 6'd5, 32'd13000);
        queue_tick(5'd23, 6'd59, 6'd59, 32'd13001);
        // Smart skip with out-of-range time fields, then a one-step catch-up.
        queue_item(REQ_SET, 5'd0, 6'd0, 6'd0, 32'd13001, 6'd62, 1'b0);
        queue_item(REQ_CATCHUP, 5'd31, 6'd63, 6'd63, 32'd13001, 6'd0, 1'b1);
        queue_item(REQ_SET, 5'd0, 6'd0, 6'd0, 32'd13001, 6'd2, 1'b0);
        queue_item(REQ_CATCHUP, 5'd5, 6'd59, 6'd0, 32'd20000, 6'd0, 1'b0);
        // Requests dropped while the catch-up runs.
        queue_item(REQ_SET, 5'd5, 6'd59, 6'd0, 32'd20000, 6'd9, 1'b0);
        queue_item(REQ_CATCHUP, 5'd5, 6'd59, 6'd0, 32'd20000, 6'd0, 1'b0);
        queue_item(REQ_MARK, 5'd5, 6'd59, 6'd0, 32'd20000, 6'd0, 1'b0);
        queue_tick(5'd5, 6'd59, 6'd0, 32'd25999);
        queue_tick(5'd5, 6'd59, 6'd0, 32'd26000);
        queue_tick(5'd5, 6'd59, 6'd0, 32'd26200);
        queue_tick(5'd5, 6'd59, 6'd0, 32'd32200);
        queue_tick(5'd5, 6'd59, 6'd0, 32'd32600);
        // Position wraps from the last one to zero while the millisecond counter wraps.
        queue_item(REQ_SET, 5'd5, 6'd0, 6'd0, 32'd32600, 6'd63, 1'b0);
        queue_tick(5'd5, 6'd14, 6'd0, 32'hFFFF_F000);
        queue_tick(5'd5, 6'd14, 6'd1, 32'h0000_0800);
        queue_tick(5'd5, 6'd14, 6'd1, 32'h0000_2000);
        gen_ms = 32'h0001_0000;
        queue_random_traffic(100);
        drain();

        // Zero gaps, a one-millisecond half turn, earliest offset and start hour.
        set_config(0, 0, 1, 0, 0);
        queue_random_traffic(110);
        drain();

        // Largest durations, an offset that never matches, latest start hour.
        set_config(15, 23, 65535, 65535, 65535);
        gen_ms = 32'hFFFF_0000;
        queue_random_traffic(110);
        drain();

        // Random settings with a long stretch of full-rate traffic.
        set_config($urandom_range(14), $urandom_range(23), $urandom_range(1, 50),
                   $urandom_range(50), $urandom_range(50));
        calm = 1'b1;
        queue_random_traffic(120);
        drain();
        calm = 1'b0;

        set_config(7, 5, 3, 1, 2);
        queue_random_traffic(110);
        drain();

        repeat (10) @(negedge clk);
        if (fault_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/dps_pkg.sv
rtl/core/dps_cfg.sv
rtl/core/dps_engine.sv
rtl/core/dial_plate_step_sequencer.sv
bench/tb_dial_plate_step_sequencer.sv
